[design/tcca_pkg.sv]
// Shared constants, types and helpers for the texture cell cache allocator.
`timescale 1ns / 1ps
package tcca_pkg;

  // Geometry of the cache
  localparam int NUM_PAGES    = 12;
  localparam int CELLS_X      = 16;
  localparam int CELLS_Y      = 16;
  localparam int MAX_TEXTURES = 1024;

  // Field widths
  localparam int PAGE_W   = 4;
  localparam int CX_W     = $clog2(CELLS_X);
  localparam int CY_W     = $clog2(CELLS_Y);
  localparam int ID_W     = $clog2(MAX_TEXTURES);
  localparam int OWNER_W  = ID_W + 1;
  localparam int DIM_W    = 5;
  localparam int POS_W    = 6;
  localparam int SUM_W    = 7;
  localparam int FRAME_W  = 16;
  localparam int CELL_AW  = PAGE_W + CY_W + CX_W;
  localparam int CELL_DEPTH = NUM_PAGES * CELLS_X * CELLS_Y;

  // Request codes
  localparam logic [1:0] REQ_CACHE  = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PURGE  = 2'd2;
  localparam logic [1:0] REQ_SETPG  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PLACED   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  // Configuration register indexes
  localparam logic CFG_LOCKED = 1'b0;
  localparam logic CFG_PAGES  = 1'b1;

  // One texture table entry
  typedef struct packed {
    logic               resident;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
    logic [CX_W-1:0]    x;
    logic [CY_W-1:0]    y;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
  } tex_t;

  localparam int TEX_W = $bits(tex_t);

  // Linear cell address of (page, x, y)
  function automatic logic [CELL_AW-1:0] cell_addr(input logic [PAGE_W-1:0] p,
                                                   input logic [DIM_W-1:0] x,
                                                   input logic [DIM_W-1:0] y);
    cell_addr = {p, y[CY_W-1:0], x[CX_W-1:0]};
  endfunction

endpackage

[design/tcca_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module tcca_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/texture_cell_cache_allocator.sv]
// Top level: request sequencer around the cell owner and texture table memories.
//
// Usage: after reset the block sweeps both memories clear with busy high. A
// request is taken when start is high and busy is low; its single result
// appears with done high for one cycle, and busy is already low in that
// cycle. A placement examines each cell of the target area in turn, writes
// the new area cell by cell, frees the cells of every texture it evicts and
// may go on to try further pages. A purge reads every cell of every unlocked
// page and frees the cells of each texture it finds there. The work is set by
// the one read and one write port of each memory, visited one cell at a time.
// Configuration writes are taken at any time but are meant for idle periods.
`timescale 1ns / 1ps
module texture_cell_cache_allocator
  import tcca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [ID_W-1:0]    tex_id,
  input  logic [DIM_W-1:0]   width_cells,
  input  logic [DIM_W-1:0]   height_cells,
  input  logic [FRAME_W-1:0] frame_num,
  input  logic [PAGE_W-1:0]  page_index,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [11:0]        cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic [PAGE_W-1:0]  page,
  output logic [CX_W-1:0]    cell_x,
  output logic [CY_W-1:0]    cell_y,
  output logic [PAGE_W-1:0]  fill_page
);

  // Sequencer states
  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_TEX_WAIT = 5'd2;
  localparam logic [4:0] S_PAGE     = 5'd3;
  localparam logic [4:0] S_FIT      = 5'd4;
  localparam logic [4:0] S_SC_RD    = 5'd5;
  localparam logic [4:0] S_SC_CHK   = 5'd6;
  localparam logic [4:0] S_OW_CHK   = 5'd7;
  localparam logic [4:0] S_ADV      = 5'd8;
  localparam logic [4:0] S_PLACE    = 5'd9;
  localparam logic [4:0] S_PL_TEX   = 5'd10;
  localparam logic [4:0] S_NEXTPG   = 5'd11;
  localparam logic [4:0] S_MOD      = 5'd12;
  localparam logic [4:0] S_EV_CELL  = 5'd13;
  localparam logic [4:0] S_EV_TEX   = 5'd14;
  localparam logic [4:0] S_RM_WAIT  = 5'd15;
  localparam logic [4:0] S_PG_RD    = 5'd16;
  localparam logic [4:0] S_PG_CHK   = 5'd17;
  localparam logic [4:0] S_PG_TEX   = 5'd18;
  localparam logic [4:0] S_PG_ADV   = 5'd19;
  localparam logic [4:0] S_FIN      = 5'd20;

  logic [4:0]          state;
  logic [CELL_AW-1:0]  clr;
  logic [11:0]         locked_pages;
  logic [3:0]          pages_in_use;

  // Request registers
  logic [1:0]          req_r;
  logic [ID_W-1:0]     id_r;
  logic [DIM_W-1:0]    w_r;
  logic [DIM_W-1:0]    h_r;
  logic [FRAME_W-1:0]  frame_r;
  tex_t                ent;
  tex_t                ev;
  logic [ID_W-1:0]     ev_id;
  logic [ID_W-1:0]     own_id;
  logic [4:0]          ret;
  logic [DIM_W-1:0]    cx;
  logic [DIM_W-1:0]    cy;
  logic [DIM_W-1:0]    ex;
  logic [DIM_W-1:0]    ey;
  logic [DIM_W-1:0]    attempt;
  logic [PAGE_W-1:0]   mod_val;
  logic [CELL_AW-1:0]  pa;

  // Fill cursor
  logic [PAGE_W-1:0]   fill_pg;
  logic [POS_W-1:0]    fcol;
  logic [POS_W-1:0]    frow;
  logic [DIM_W-1:0]    rh;

  // Result registers
  logic                done_r;
  logic [1:0]          res_status;
  logic [PAGE_W-1:0]   res_page;
  logic [CX_W-1:0]     res_x;
  logic [CY_W-1:0]     res_y;

  // Memory ports
  logic                cell_we;
  logic [CELL_AW-1:0]  cell_waddr;
  logic [OWNER_W-1:0]  cell_wdata;
  logic [CELL_AW-1:0]  cell_raddr;
  logic [OWNER_W-1:0]  cell_q;
  logic                tex_we;
  logic [ID_W-1:0]     tex_waddr;
  tex_t                tex_wdata;
  logic [ID_W-1:0]     tex_raddr;
  tex_t                tex_q;

  tcca_ram #(.DEPTH(CELL_DEPTH), .WIDTH(OWNER_W), .AW(CELL_AW)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_q)
  );

  tcca_ram #(.DEPTH(MAX_TEXTURES), .WIDTH(TEX_W), .AW(ID_W)) u_tex_ram (
    .clk   (clk),
    .we    (tex_we),
    .waddr (tex_waddr),
    .wdata (tex_wdata),
    .raddr (tex_raddr),
    .rdata (tex_q)
  );

  // Effective page count
  logic [PAGE_W-1:0] pc;
  always_comb begin
    if (pages_in_use == '0) begin
      pc = PAGE_W'(1);
    end else if (pages_in_use > PAGE_W'(NUM_PAGES)) begin
      pc = PAGE_W'(NUM_PAGES);
    end else begin
      pc = pages_in_use;
    end
  end

  // Clamped request size
  logic [DIM_W-1:0] w_in;
  logic [DIM_W-1:0] h_in;
  always_comb begin
    w_in = width_cells;
    if (width_cells == '0) w_in = DIM_W'(1);
    if (width_cells > DIM_W'(CELLS_X)) w_in = DIM_W'(CELLS_X);
    h_in = height_cells;
    if (height_cells == '0) h_in = DIM_W'(1);
    if (height_cells > DIM_W'(CELLS_Y)) h_in = DIM_W'(CELLS_Y);
  end

  // Lock checks for the cursor page and the purge page
  logic [PAGE_W-1:0] pg_page;
  logic              cur_locked;
  logic              pg_locked;
  assign pg_page    = pa[CELL_AW-1 -: PAGE_W];
  assign cur_locked = (fill_pg >= PAGE_W'(NUM_PAGES)) || locked_pages[fill_pg];
  assign pg_locked  = (pg_page < PAGE_W'(NUM_PAGES)) && locked_pages[pg_page];

  // Row wrap at the cursor
  logic             wrap;
  logic [POS_W-1:0] col2;
  logic [POS_W-1:0] row2;
  logic [SUM_W-1:0] row2_end;
  assign wrap     = ({1'b0, fcol} + SUM_W'(w_r)) > SUM_W'(CELLS_X);
  assign col2     = wrap ? '0 : fcol;
  assign row2     = wrap ? POS_W'(frow + POS_W'(rh)) : frow;
  assign row2_end = {1'b0, row2} + SUM_W'(h_r);

  // Area walk over the target region
  logic last_x;
  logic last_y;
  assign last_x = (POS_W'(cx) + POS_W'(1)) == (fcol + POS_W'(w_r));
  assign last_y = (POS_W'(cy) + POS_W'(1)) == (frow + POS_W'(h_r));

  // Area walk over an evicted texture
  logic ev_last_x;
  logic ev_last_y;
  logic ev_in;
  assign ev_last_x = ((POS_W'(ex) + POS_W'(1)) == (POS_W'(ev.x) + POS_W'(ev.w))) ||
                     ((POS_W'(ex) + POS_W'(1)) >= POS_W'(CELLS_X));
  assign ev_last_y = ((POS_W'(ey) + POS_W'(1)) == (POS_W'(ev.y) + POS_W'(ev.h))) ||
                     ((POS_W'(ey) + POS_W'(1)) >= POS_W'(CELLS_Y));
  assign ev_in     = (ev.page < PAGE_W'(NUM_PAGES)) && (ex < DIM_W'(CELLS_X)) &&
                     (ey < DIM_W'(CELLS_Y));

  logic [OWNER_W-1:0] own_m1;
  assign own_m1 = cell_q - OWNER_W'(1);

  // Memory port control
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = '0;
    cell_raddr = '0;
    tex_we     = 1'b0;
    tex_waddr  = '0;
    tex_wdata  = '0;
    tex_raddr  = '0;
    case (state)
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr;
        tex_we     = clr < CELL_AW'(MAX_TEXTURES);
        tex_waddr  = clr[ID_W-1:0];
      end
      S_IDLE: begin
        tex_raddr = tex_id;
      end
      S_TEX_WAIT: begin
        if (tex_q.resident) begin
          tex_we          = 1'b1;
          tex_waddr       = id_r;
          tex_wdata       = tex_q;
          tex_wdata.frame = frame_r;
        end
      end
      S_SC_RD: begin
        cell_raddr = cell_addr(fill_pg, cx, cy);
      end
      S_SC_CHK: begin
        tex_raddr = own_m1[ID_W-1:0];
      end
      S_PLACE: begin
        cell_we    = 1'b1;
        cell_waddr = cell_addr(fill_pg, cx, cy);
        cell_wdata = {1'b0, id_r} + OWNER_W'(1);
      end
      S_PL_TEX: begin
        tex_we    = 1'b1;
        tex_waddr = id_r;
        tex_wdata = '{resident: 1'b1, frame: frame_r, page: fill_pg,
                      x: fcol[CX_W-1:0], y: frow[CY_W-1:0], w: w_r, h: h_r};
      end
      S_MOD: begin
        tex_we    = (mod_val < pc) && (req_r == REQ_CACHE) &&
                    ((attempt + DIM_W'(1)) == (DIM_W'(pc) + DIM_W'(1)));
        tex_waddr = id_r;
        tex_wdata = ent;
      end
      S_EV_CELL: begin
        cell_we    = ev_in;
        cell_waddr = cell_addr(ev.page, ex, ey);
      end
      S_EV_TEX: begin
        tex_we    = 1'b1;
        tex_waddr = ev_id;
        tex_wdata = '{resident: 1'b0, frame: ev.frame, page: '0, x: '0, y: '0,
                      w: ev.w, h: ev.h};
      end
      S_PG_RD: begin
        cell_raddr = pa;
      end
      S_PG_CHK: begin
        tex_raddr = own_m1[ID_W-1:0];
      end
      S_PG_TEX: begin
        cell_we    = 1'b1;
        cell_waddr = pa;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      locked_pages <= '0;
      pages_in_use <= 4'(NUM_PAGES);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LOCKED: locked_pages <= cfg_data;
        CFG_PAGES:  pages_in_use <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      done_r  <= 1'b0;
      fill_pg <= '0;
      fcol    <= '0;
      frow    <= '0;
      rh      <= '0;
    end else begin
      done_r <= 1'b0;
      case (state)
        // Sweep both memories clear
        S_CLEAR: begin
          clr <= clr + CELL_AW'(1);
          if (clr == CELL_AW'(CELL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        // Take an item
        S_IDLE: begin
          if (start) begin
            req_r   <= req_type;
            id_r    <= tex_id;
            w_r     <= w_in;
            h_r     <= h_in;
            frame_r <= frame_num;
            mod_val <= page_index;
            pa      <= '0;
            case (req_type)
              REQ_CACHE:  state <= S_TEX_WAIT;
              REQ_REMOVE: state <= S_RM_WAIT;
              REQ_PURGE:  state <= S_PG_RD;
              default:    state <= S_MOD;
            endcase
          end
        end
        // Stamp frame; hit or start placement
        S_TEX_WAIT: begin
          ent     <= {tex_q.resident, frame_r, tex_q.page, tex_q.x, tex_q.y,
                      tex_q.w, tex_q.h};
          attempt <= '0;
          if (tex_q.resident) begin
            res_status <= ST_HIT;
            res_page   <= tex_q.page;
            res_x      <= tex_q.x;
            res_y      <= tex_q.y;
            state      <= S_FIN;
          end else begin
            state <= S_PAGE;
          end
        end
        S_PAGE: begin
          state <= cur_locked ? S_NEXTPG : S_FIT;
        end
        // Wrap to the next row if needed, then check the bottom
        S_FIT: begin
          fcol <= col2;
          frow <= row2;
          rh   <= wrap ? '0 : rh;
          cx   <= col2[DIM_W-1:0];
          cy   <= row2[DIM_W-1:0];
          state <= (row2_end > SUM_W'(CELLS_Y)) ? S_NEXTPG : S_SC_RD;
        end
        S_SC_RD: begin
          state <= S_SC_CHK;
        end
        S_SC_CHK: begin
          own_id <= own_m1[ID_W-1:0];
          state  <= (cell_q == '0) ? S_ADV : S_OW_CHK;
        end
        // Owner of the cell: skip past a current one, evict a stale one
        S_OW_CHK: begin
          if (tex_q.frame == frame_r) begin
            fcol  <= fcol + POS_W'(tex_q.w);
            rh    <= (tex_q.h > rh) ? tex_q.h : rh;
            state <= S_FIT;
          end else if (tex_q.resident) begin
            ev    <= tex_q;
            ev_id <= own_id;
            ex    <= DIM_W'(tex_q.x);
            ey    <= DIM_W'(tex_q.y);
            ret   <= S_ADV;
            state <= S_EV_CELL;
          end else begin
            state <= S_ADV;
          end
        end
        // Advance to the next cell of the area
        S_ADV: begin
          if (last_x) begin
            cx <= fcol[DIM_W-1:0];
            if (last_y) begin
              cy    <= frow[DIM_W-1:0];
              state <= S_PLACE;
            end else begin
              cy    <= cy + DIM_W'(1);
              state <= S_SC_RD;
            end
          end else begin
            cx    <= cx + DIM_W'(1);
            state <= S_SC_RD;
          end
        end
        // Claim the area cell by cell
        S_PLACE: begin
          if (last_x) begin
            cx <= fcol[DIM_W-1:0];
            cy <= cy + DIM_W'(1);
            if (last_y) begin
              state <= S_PL_TEX;
            end
          end else begin
            cx <= cx + DIM_W'(1);
          end
        end
        S_PL_TEX: begin
          res_status <= ST_PLACED;
          res_page   <= fill_pg;
          res_x      <= fcol[CX_W-1:0];
          res_y      <= frow[CY_W-1:0];
          fcol       <= fcol + POS_W'(w_r);
          rh         <= (h_r > rh) ? h_r : rh;
          state      <= S_FIN;
        end
        S_NEXTPG: begin
          mod_val <= fill_pg + PAGE_W'(1);
          state   <= S_MOD;
        end
        // Reduce modulo the page count, then move the cursor
        S_MOD: begin
          if (mod_val >= pc) begin
            mod_val <= mod_val - pc;
          end else begin
            fill_pg <= mod_val;
            fcol    <= '0;
            frow    <= '0;
            rh      <= '0;
            res_page <= '0;
            res_x    <= '0;
            res_y    <= '0;
            if (req_r == REQ_CACHE) begin
              attempt <= attempt + DIM_W'(1);
              if ((attempt + DIM_W'(1)) == (DIM_W'(pc) + DIM_W'(1))) begin
                res_status <= ST_OVERFLOW;
                state      <= S_FIN;
              end else begin
                state <= S_PAGE;
              end
            end else begin
              res_status <= ST_DONE;
              state      <= S_FIN;
            end
          end
        end
        // Free the cells of an evicted texture
        S_EV_CELL: begin
          if (ev_last_x) begin
            ex <= DIM_W'(ev.x);
            if (ev_last_y) begin
              state <= S_EV_TEX;
            end else begin
              ey <= ey + DIM_W'(1);
            end
          end else begin
            ex <= ex + DIM_W'(1);
          end
        end
        S_EV_TEX: begin
          state <= ret;
        end
        // Remove one texture
        S_RM_WAIT: begin
          res_status <= ST_DONE;
          res_page   <= '0;
          res_x      <= '0;
          res_y      <= '0;
          if (tex_q.resident) begin
            ev    <= tex_q;
            ev_id <= id_r;
            ex    <= DIM_W'(tex_q.x);
            ey    <= DIM_W'(tex_q.y);
            ret   <= S_FIN;
            state <= S_EV_CELL;
          end else begin
            state <= S_FIN;
          end
        end
        // Purge: walk every cell of the unlocked pages
        S_PG_RD: begin
          if (pg_locked) begin
            if (pg_page == PAGE_W'(NUM_PAGES - 1)) begin
              fill_pg    <= '0;
              fcol       <= '0;
              frow       <= '0;
              rh         <= '0;
              res_status <= ST_DONE;
              res_page   <= '0;
              res_x      <= '0;
              res_y      <= '0;
              state      <= S_FIN;
            end else begin
              pa <= {pg_page + PAGE_W'(1), {(CY_W + CX_W){1'b0}}};
            end
          end else begin
            state <= S_PG_CHK;
          end
        end
        S_PG_CHK: begin
          own_id <= own_m1[ID_W-1:0];
          state  <= (cell_q == '0) ? S_PG_ADV : S_PG_TEX;
        end
        S_PG_TEX: begin
          if (tex_q.resident) begin
            ev    <= tex_q;
            ev_id <= own_id;
            ex    <= DIM_W'(tex_q.x);
            ey    <= DIM_W'(tex_q.y);
            ret   <= S_PG_ADV;
            state <= S_EV_CELL;
          end else begin
            state <= S_PG_ADV;
          end
        end
        S_PG_ADV: begin
          if (pa == CELL_AW'(CELL_DEPTH - 1)) begin
            fill_pg    <= '0;
            fcol       <= '0;
            frow       <= '0;
            rh         <= '0;
            res_status <= ST_DONE;
            res_page   <= '0;
            res_x      <= '0;
            res_y      <= '0;
            state      <= S_FIN;
          end else begin
            pa    <= pa + CELL_AW'(1);
            state <= S_PG_RD;
          end
        end
        // Deliver the result
        S_FIN: begin
          done_r <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign done      = done_r;
  assign status    = res_status;
  assign page      = res_page;
  assign cell_x    = res_x;
  assign cell_y    = res_y;
  assign fill_page = fill_pg;

`ifndef ASSERT_OFF
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIN)
    else $error("result without a finished item");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  a_row_height: assert property (@(posedge clk) disable iff (rst)
    rh <= DIM_W'(CELLS_Y))
    else $error("row height beyond page");

  a_place_owner: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE) |-> (cell_we && cell_wdata != '0))
    else $error("placement writes an empty owner");

  a_cursor_page: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> fill_pg < PAGE_W'(NUM_PAGES))
    else $error("cursor page out of range");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the texture cell cache allocator.
`timescale 1ns / 1ps
module testbench;
  import tcca_pkg::*;

  typedef struct {
    logic [1:0]        status;
    logic [PAGE_W-1:0] page;
    logic [CX_W-1:0]   cell_x;
    logic [CY_W-1:0]   cell_y;
    logic [PAGE_W-1:0] fill_page;
  } alloc_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = REQ_CACHE;
  logic [ID_W-1:0] tex_id = '0;
  logic [DIM_W-1:0] width_cells = 5'd1;
  logic [DIM_W-1:0] height_cells = 5'd1;
  logic [FRAME_W-1:0] frame_num = '0;
  logic [PAGE_W-1:0] page_index = '0;
  logic cfg_we = 1'b0;
  logic cfg_addr = CFG_LOCKED;
  logic [11:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic [PAGE_W-1:0] page;
  logic [CX_W-1:0] cell_x;
  logic [CY_W-1:0] cell_y;
  logic [PAGE_W-1:0] fill_page;

  texture_cell_cache_allocator dut (.*);

  always #2 clk = ~clk;

  // Predictor state: cell owners (id+1, 0 = empty), texture table, cursor, registers
  logic [OWNER_W-1:0] owner_m [CELL_DEPTH];
  tex_t tex_m [MAX_TEXTURES];
  int unsigned cur_page, cur_col, cur_row, cur_rowh;
  logic [11:0] locked_m;
  logic [3:0] pages_m;

  alloc_res_t placement_q[$];
  int errors = 0;
  int idle_pct = 0;
  int unsigned cycles = 0;
  logic [FRAME_W-1:0] cur_frame = 16'd1;

  function automatic int unsigned cell_ix(int unsigned p, int unsigned x, int unsigned y);
    return (p * CELLS_Y + y) * CELLS_X + x;
  endfunction

  function automatic int unsigned live_pages();
    if (pages_m == 0) return 1;
    if (pages_m > NUM_PAGES) return NUM_PAGES;
    return pages_m;
  endfunction

  function automatic bit is_locked(int unsigned p);
    return p < NUM_PAGES && locked_m[p];
  endfunction

  function automatic void move_cursor(int unsigned p);
    cur_page = p;
    cur_col = 0;
    cur_row = 0;
    cur_rowh = 0;
  endfunction

  // Free every cell of a resident texture and mark it gone
  function automatic void drop_texture(int unsigned id);
    if (!tex_m[id].resident) return;
    for (int unsigned y = tex_m[id].y; y < tex_m[id].y + tex_m[id].h && y < CELLS_Y; y++)
      for (int unsigned x = tex_m[id].x; x < tex_m[id].x + tex_m[id].w && x < CELLS_X; x++)
        if (tex_m[id].page < NUM_PAGES) owner_m[cell_ix(tex_m[id].page, x, y)] = '0;
    tex_m[id].resident = 1'b0;
    tex_m[id].page = '0;
    tex_m[id].x = '0;
    tex_m[id].y = '0;
  endfunction

  // Evict stale owners under the cursor area; skip past a current-frame owner
  function automatic bit area_free(int unsigned p, int unsigned w, int unsigned h,
                                   logic [FRAME_W-1:0] fr);
    int unsigned o;
    for (int unsigned y = cur_row; y < cur_row + h; y++)
      for (int unsigned x = cur_col; x < cur_col + w; x++) begin
        if (x >= CELLS_X || y >= CELLS_Y) continue;
        o = owner_m[cell_ix(p, x, y)];
        if (o == 0) continue;
        o = o - 1;
        if (tex_m[o].frame == fr) begin
          cur_col += tex_m[o].w;
          if (tex_m[o].h > cur_rowh) cur_rowh = tex_m[o].h;
          return 1'b0;
        end
        drop_texture(o);
        owner_m[cell_ix(p, x, y)] = '0;
      end
    return 1'b1;
  endfunction

  function automatic bit fit_on_page(int unsigned w, int unsigned h, logic [FRAME_W-1:0] fr);
    int unsigned p;
    p = cur_page;
    if (p >= NUM_PAGES || is_locked(p)) return 1'b0;
    forever begin
      if (cur_col + w > CELLS_X) begin
        cur_col = 0;
        cur_row += cur_rowh;
        cur_rowh = 0;
      end
      if (cur_row + h > CELLS_Y) return 1'b0;
      if (area_free(p, w, h, fr)) return 1'b1;
    end
  endfunction

  // Apply one request to the predictor and return the expected result
  function automatic alloc_res_t predict_request(logic [1:0] rq, logic [ID_W-1:0] id,
      logic [DIM_W-1:0] wi, logic [DIM_W-1:0] hi, logic [FRAME_W-1:0] fr,
      logic [PAGE_W-1:0] pi);
    alloc_res_t r;
    int unsigned w, h, n;
    bit ok;
    w = (wi < 1) ? 1 : (wi > CELLS_X) ? CELLS_X : wi;
    h = (hi < 1) ? 1 : (hi > CELLS_Y) ? CELLS_Y : hi;
    n = live_pages();
    r.status = ST_DONE;
    r.page = '0;
    r.cell_x = '0;
    r.cell_y = '0;
    case (rq)
      REQ_CACHE: begin
        r.status = ST_OVERFLOW;
        tex_m[id].frame = fr;
        if (tex_m[id].resident) begin
          r.status = ST_HIT;
          r.page = tex_m[id].page;
          r.cell_x = tex_m[id].x;
          r.cell_y = tex_m[id].y;
        end else begin
          ok = 1'b0;
          for (int i = 0; i < n + 1; i++) begin
            if (fit_on_page(w, h, fr)) begin
              ok = 1'b1;
              break;
            end
            move_cursor((cur_page + 1) % n);
          end
          if (ok) begin
            for (int unsigned y = cur_row; y < cur_row + h; y++)
              for (int unsigned x = cur_col; x < cur_col + w; x++)
                owner_m[cell_ix(cur_page, x, y)] = id + 1;
            tex_m[id].resident = 1'b1;
            tex_m[id].page = cur_page;
            tex_m[id].x = cur_col;
            tex_m[id].y = cur_row;
            tex_m[id].w = w;
            tex_m[id].h = h;
            r.status = ST_PLACED;
            r.page = cur_page;
            r.cell_x = cur_col;
            r.cell_y = cur_row;
            cur_col += w;
            if (h > cur_rowh) cur_rowh = h;
          end
        end
      end
      REQ_REMOVE: drop_texture(id);
      REQ_PURGE: begin
        for (int unsigned p = 0; p < NUM_PAGES; p++) begin
          if (is_locked(p)) continue;
          for (int unsigned c = 0; c < CELLS_X * CELLS_Y; c++)
            if (owner_m[p * CELLS_X * CELLS_Y + c] != 0) begin
              drop_texture(owner_m[p * CELLS_X * CELLS_Y + c] - 1);
              owner_m[p * CELLS_X * CELLS_Y + c] = '0;
            end
        end
        move_cursor(0);
      end
      default: move_cursor(pi % n);
    endcase
    r.fill_page = cur_page;
    return r;
  endfunction

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    alloc_res_t e;
    if (!rst && done) begin
      if (placement_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status);
        errors++;
      end else begin
        e = placement_q.pop_front();
        if (status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status);
          errors++;
        end
        if (page !== e.page) begin
          $display("%0t: page exp %0d got %0d", $time, e.page, page);
          errors++;
        end
        if (cell_x !== e.cell_x) begin
          $display("%0t: cell_x exp %0d got %0d", $time, e.cell_x, cell_x);
          errors++;
        end
        if (cell_y !== e.cell_y) begin
          $display("%0t: cell_y exp %0d got %0d", $time, e.cell_y, cell_y);
          errors++;
        end
        if (fill_page !== e.fill_page) begin
          $display("%0t: fill_page exp %0d got %0d", $time, e.fill_page, fill_page);
          errors++;
        end
      end
    end
  end

  // Drive one item, hold start until accepted, record its prediction
  task automatic send_item(logic [1:0] rq, logic [ID_W-1:0] id, logic [DIM_W-1:0] w,
                           logic [DIM_W-1:0] h, logic [FRAME_W-1:0] fr,
                           logic [PAGE_W-1:0] pi);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    req_type = rq;
    tex_id = id;
    width_cells = w;
    height_cells = h;
    frame_num = fr;
    page_index = pi;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    placement_q.push_back(predict_request(rq, id, w, h, fr, pi));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (placement_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Write one register while idle
  task automatic write_reg(logic idx, logic [11:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_LOCKED) locked_m = val;
    else pages_m = val[3:0];
  endtask

  task automatic random_item();
    int r;
    logic [DIM_W-1:0] w, h;
    logic [ID_W-1:0] id;
    logic [FRAME_W-1:0] fr;
    r = $urandom_range(99);
    id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(1023)) : ID_W'($urandom_range(47));
    w = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(31)) : DIM_W'($urandom_range(1, 6));
    h = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(31)) : DIM_W'($urandom_range(1, 6));
    if ($urandom_range(6) == 0) cur_frame = cur_frame + 1;
    fr = ($urandom_range(19) == 0) ? FRAME_W'($urandom) : cur_frame;
    if (r < 72) send_item(REQ_CACHE, id, w, h, fr, 4'($urandom));
    else if (r < 88) send_item(REQ_REMOVE, id, w, h, fr, 4'($urandom));
    else if (r < 91) send_item(REQ_PURGE, id, w, h, fr, 4'($urandom));
    else send_item(REQ_SETPG, id, w, h, fr, 4'($urandom_range(15)));
  endtask

  // Extremes, every request, blocking, clamping and cursor corner cases
  task automatic test_directed();
    send_item(REQ_CACHE, 10'd0, 5'd16, 5'd16, 16'd0, 4'd0);
    send_item(REQ_CACHE, 10'd1023, 5'd0, 5'd0, 16'hFFFF, 4'd15);
    send_item(REQ_CACHE, 10'd0, 5'd3, 5'd3, 16'd0, 4'd0);
    send_item(REQ_CACHE, 10'd5, 5'd31, 5'd17, 16'd0, 4'd0);
    send_item(REQ_CACHE, 10'd6, 5'd4, 5'd2, 16'd7, 4'd0);
    send_item(REQ_CACHE, 10'd7, 5'd4, 5'd5, 16'd7, 4'd0);
    send_item(REQ_SETPG, 10'd0, 5'd1, 5'd1, 16'd7, 4'd1);
    send_item(REQ_CACHE, 10'd8, 5'd16, 5'd16, 16'd7, 4'd0);
    send_item(REQ_REMOVE, 10'd500, 5'd1, 5'd1, 16'd7, 4'd0);
    send_item(REQ_REMOVE, 10'd6, 5'd1, 5'd1, 16'd7, 4'd0);
    send_item(REQ_SETPG, 10'd0, 5'd1, 5'd1, 16'd8, 4'd15);
    send_item(REQ_SETPG, 10'd0, 5'd1, 5'd1, 16'd8, 4'd11);
    send_item(REQ_CACHE, 10'd9, 5'd16, 5'd16, 16'd8, 4'd0);
    send_item(REQ_PURGE, 10'd0, 5'd1, 5'd1, 16'd8, 4'd0);
    send_item(REQ_CACHE, 10'd0, 5'd3, 5'd3, 16'd9, 4'd0);
  endtask

  // Locked pages, page count extremes and a cursor left beyond the count
  task automatic test_config();
    write_reg(CFG_LOCKED, 12'h001);
    send_item(REQ_CACHE, 10'd20, 5'd2, 5'd2, 16'd9, 4'd0);
    send_item(REQ_PURGE, 10'd0, 5'd1, 5'd1, 16'd9, 4'd0);
    send_item(REQ_CACHE, 10'd21, 5'd2, 5'd2, 16'd9, 4'd0);
    write_reg(CFG_LOCKED, 12'hFFF);
    send_item(REQ_CACHE, 10'd22, 5'd2, 5'd2, 16'd9, 4'd0);
    write_reg(CFG_LOCKED, 12'h000);
    send_item(REQ_SETPG, 10'd0, 5'd1, 5'd1, 16'd9, 4'd11);
    write_reg(CFG_PAGES, 12'd3);
    send_item(REQ_CACHE, 10'd23, 5'd16, 5'd16, 16'd9, 4'd0);
    send_item(REQ_SETPG, 10'd0, 5'd1, 5'd1, 16'd9, 4'd7);
    write_reg(CFG_PAGES, 12'd0);
    send_item(REQ_CACHE, 10'd24, 5'd16, 5'd16, 16'd9, 4'd0);
    send_item(REQ_CACHE, 10'd25, 5'd16, 5'd16, 16'd9, 4'd0);
    write_reg(CFG_PAGES, 12'd15);
    send_item(REQ_SETPG, 10'd0, 5'd1, 5'd1, 16'd9, 4'd13);
    write_reg(CFG_PAGES, 12'd12);
  endtask

  task automatic test_random(int count, int pct, logic [11:0] lock, logic [3:0] pages);
    write_reg(CFG_LOCKED, lock);
    write_reg(CFG_PAGES, {8'd0, pages});
    idle_pct = pct;
    repeat (count) random_item();
  endtask

  initial begin
    for (int i = 0; i < CELL_DEPTH; i++) owner_m[i] = '0;
    for (int i = 0; i < MAX_TEXTURES; i++) tex_m[i] = '0;
    move_cursor(0);
    locked_m = '0;
    pages_m = 4'd12;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config();
    test_random(200, 0, 12'h000, 4'd12);
    test_random(150, 83, 12'($urandom), 4'd4);
    test_random(150, 0, 12'h000, 4'd1);
    test_random(200, 25, 12'($urandom), 4'($urandom_range(1, 12)));
    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tcca_pkg.sv
design/tcca_ram.sv
design/texture_cell_cache_allocator.sv
tb/testbench.sv
